// File: hw/rtl/upd_pkg.sv
// Package for the URL percent-decoder: byte constants, held-state codes,
// the result bundle type and the hex digit helpers. No dependencies.
package upd_pkg;

  localparam logic [7:0] UPD_PCT   = 8'h25;
  localparam logic [7:0] UPD_PLUS  = 8'h2B;
  localparam logic [7:0] UPD_SPACE = 8'h20;
  localparam logic [4:0] UPD_HEX_MASK = 5'h1F;

  localparam int unsigned UPD_MAX_OUT = 3;

  // State code three has no member and behaves as empty.
  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_state_t;

  // Up to three decoded bytes produced by one input transfer.
  typedef struct packed {
    logic [UPD_MAX_OUT-1:0][7:0] bytes;
    logic [1:0]                  count;
    logic                        last;
  } upd_bundle_t;

  // A digit is judged by its low five bits: 1..6 are a..f, 16..25 are 0..9.
  function automatic logic hex_valid(input logic [7:0] b);
    logic [4:0] idx;
    idx = b[4:0] & UPD_HEX_MASK;
    return ((idx >= 5'd1) && (idx <= 5'd6)) || ((idx >= 5'd16) && (idx <= 5'd25));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [4:0] idx;
    logic [4:0] v;
    idx = b[4:0] & UPD_HEX_MASK;
    if (idx <= 5'd6) begin
      v = idx + 5'd9;
    end else begin
      v = idx - 5'd16;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] b);
    return (b == UPD_PLUS) ? UPD_SPACE : b;
  endfunction

endpackage

// File: hw/rtl/upd_if.sv
// Stream interfaces for the URL percent-decoder: encoded bytes in and
// decoded bytes out, each with valid/ready. Depends on nothing.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hw/rtl/upd_decode.sv
// Escape tracker of the URL percent-decoder: holds the pending '%' and first
// digit, and forms the bundle of decoded bytes for each input. Uses upd_pkg.
module upd_decode
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output upd_bundle_t bundle,
  output held_state_t held_state
);

  held_state_t state_r, state_nxt;
  logic [7:0]  digit_r, digit_nxt;
  logic        hb_ok;

  assign hb_ok      = hex_valid(in_byte);
  assign held_state = state_r;

  always_comb begin
    state_nxt     = HELD_NONE;
    digit_nxt     = digit_r;
    bundle.bytes  = '0;
    bundle.count  = 2'd0;
    bundle.last   = in_last;
    unique case (state_r)
      HELD_PCT: begin
        if (hb_ok && !in_last) begin
          state_nxt = HELD_DIGIT;
          digit_nxt = in_byte;
        end else begin
          bundle.bytes[0] = UPD_PCT;
          bundle.bytes[1] = plain(in_byte);
          bundle.count    = 2'd2;
        end
      end
      HELD_DIGIT: begin
        if (hb_ok) begin
          bundle.bytes[0] = {hex_value(digit_r), hex_value(in_byte)};
          bundle.count    = 2'd1;
        end else begin
          // The escape is broken: the '%' and the held digit go out as they were.
          bundle.bytes[0] = UPD_PCT;
          bundle.bytes[1] = digit_r;
          bundle.bytes[2] = plain(in_byte);
          bundle.count    = 2'd3;
        end
      end
      default: begin
        if ((in_byte == UPD_PCT) && !in_last) begin
          state_nxt = HELD_PCT;
        end else begin
          bundle.bytes[0] = plain(in_byte);
          bundle.count    = 2'd1;
        end
      end
    endcase
    if (in_last) begin
      state_nxt = HELD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HELD_NONE;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digit_r <= digit_nxt;
    end
  end

endmodule

// File: hw/rtl/upd_emit.sv
// Result register of the URL percent-decoder: holds one bundle and hands its
// bytes out one transfer at a time. Uses upd_pkg.
module upd_emit
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  upd_bundle_t bundle,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [UPD_MAX_OUT-1:0][7:0] bytes_r, bytes_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic                        last_r, last_nxt;
  logic                        take;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && out_ready;
  // A new bundle may enter while the final byte of the current one leaves.
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_byte  = bytes_r[0];
  assign out_last  = last_r && (cnt_r == 2'd1);

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    if (load) begin
      bytes_nxt = bundle.bytes;
      cnt_nxt   = bundle.count;
      last_nxt  = bundle.last;
    end else if (take) begin
      bytes_nxt = {8'h00, bytes_r[2], bytes_r[1]};
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    last_r  <= last_nxt;
  end

endmodule

// File: hw/rtl/url_percent_decoder_core.sv
// Top level of the URL percent-decoder: escape tracker and result register.
// Depends on upd_pkg, upd_if, upd_decode and upd_emit.
//
//   channel   direction  handshake        payload
//   in_ch     in         valid / ready    in_byte[7:0], in_last
//   out_ch    out        valid / ready    out_byte[7:0], out_last
//
// A byte is decoded in the cycle of its transfer and its results appear in the
// result register on the next cycle, so one byte per cycle passes through while
// out_ch accepts. A byte that yields two or three results keeps in_ch.ready low
// while the result register drains them.
// Reset (rst_n low, synchronous) empties the escape tracker and result register.
// A stall on out_ch blocks input for as long as the result register holds a byte.
module url_percent_decoder_core
  import upd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  upd_in_if.sink   in_ch,
  upd_out_if.source out_ch
);

  upd_bundle_t bundle;
  held_state_t held_state;
  logic        accept;
  logic        load;
  logic        can_load;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;
  assign load        = accept && (bundle.count != 2'd0);

  upd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_ch.in_byte),
    .in_last    (in_ch.in_last),
    .bundle     (bundle),
    .held_state (held_state)
  );

  upd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
  );

  // The final byte of a string always produces at least one result.
  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.in_last |-> load)
    else $error("final byte produced no result");

  // After the final byte of a string nothing stays held.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.in_last |=> held_state == HELD_NONE)
    else $error("escape still held after end of string");

  // The second digit always closes the escape.
  a_digit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (held_state == HELD_DIGIT) |=> held_state == HELD_NONE)
    else $error("escape not closed after second digit");

endmodule
